// File: rtl/png_stored_deflate_encoder_defines.svh
// ----------------------------------------------------------------------------
// png_stored_deflate_encoder_defines
// Assertion macros for the encoder modules.
// ----------------------------------------------------------------------------
`ifndef PNG_STORED_DEFLATE_ENCODER_DEFINES_SVH
`define PNG_STORED_DEFLATE_ENCODER_DEFINES_SVH

// same-cycle implication, clocked by clk, off during reset
`define PSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked by clk, off during reset
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Types and constants shared by the stored-deflate PNG encoder modules.
// ----------------------------------------------------------------------------
package psd_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    // most bytes one pixel may produce
    localparam int unsigned MAX_OUT = 64;

    // last byte index of each byte sequence
    localparam logic [5:0] HEAD_LAST = 6'd42;
    localparam logic [5:0] TAIL_LAST = 6'd19;
    localparam logic [5:0] BLK_LAST  = 6'd4;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;

    // one classified pixel item handed from front to back
    typedef struct packed {
        logic        tail_only;
        logic        hdr;
        logic        filter;
        logic        tail_after;
        logic [31:0] pixel;
        logic [14:0] w;
        logic [14:0] h;
    } cmd_t;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/psd_if.sv
// ----------------------------------------------------------------------------
// psd_if
// Valid/ready channels of the encoder: pixels, output bytes, configuration.
// ----------------------------------------------------------------------------
interface psd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface psd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       file_end;
    modport source (output valid, out_byte, run_end, file_end, input ready);
    modport sink   (input valid, out_byte, run_end, file_end, output ready);
endinterface

interface psd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [14:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Accepts pixels, tracks row and column framing and classifies each item.
// ----------------------------------------------------------------------------
module psd_front
    import psd_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = 16384
)
(
    input  logic       clk,
    input  logic       rst_n,
    psd_cfg_if.sink    cfg,
    psd_pix_if.sink    pix,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_data
);

    localparam logic [14:0] DIM_MAX = 15'(MAX_DIMENSION);

    logic [14:0] width_reg, width_next;
    logic [14:0] height_reg, height_next;
    logic [14:0] cur_w_reg, cur_w_next;
    logic [14:0] cur_h_reg, cur_h_next;
    logic [13:0] col_reg, col_next;
    logic [13:0] row_reg, row_next;
    logic        hd_reg, hd_next;
    logic        tp_reg, tp_next;

    logic [14:0] w_sel, h_sel, w_clamp, h_clamp;
    logic [13:0] col_base, row_base;
    logic [14:0] col_inc, row_inc;
    logic        hdr;

    assign cfg.ready = 1'b1;
    assign pix.ready = !q_full;
    assign q_push    = pix.valid && !q_full;

    // dimension saturation into 1..max
    always_comb
    begin
        w_clamp = (width_reg == 15'd0) ? 15'd1 : ((width_reg > DIM_MAX) ? DIM_MAX : width_reg);
        h_clamp = (height_reg == 15'd0) ? 15'd1 : ((height_reg > DIM_MAX) ? DIM_MAX : height_reg);
    end

    // classify the item and advance framing
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        cur_w_next  = cur_w_reg;
        cur_h_next  = cur_h_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        hd_next     = hd_reg;
        tp_next     = tp_reg;

        hdr      = !hd_reg;
        w_sel    = hdr ? w_clamp : cur_w_reg;
        h_sel    = hdr ? h_clamp : cur_h_reg;
        col_base = hdr ? 14'd0 : col_reg;
        row_base = hdr ? 14'd0 : row_reg;
        col_inc  = {1'b0, col_base} + 15'd1;
        row_inc  = {1'b0, row_base} + 15'd1;

        q_data            = '0;
        q_data.pixel      = {pix.red, pix.green, pix.blue, pix.alpha};
        q_data.w          = w_sel;
        q_data.h          = h_sel;

        if (cfg.valid && cfg.index == REG_WIDTH)
        begin
            width_next = cfg.data;
        end
        if (cfg.valid && cfg.index == REG_HEIGHT)
        begin
            height_next = cfg.data;
        end

        if (tp_reg)
        begin
            q_data.tail_only = 1'b1;
            q_data.w         = cur_w_reg;
            q_data.h         = cur_h_reg;
        end
        else
        begin
            q_data.hdr    = hdr;
            q_data.filter = (col_base == 14'd0);
            // the trailer goes with the last pixel unless that pixel also held the header
            q_data.tail_after = !hdr && (col_inc >= w_sel) && (row_inc >= h_sel);
        end

        if (q_push)
        begin
            if (tp_reg)
            begin
                tp_next = 1'b0;
                hd_next = 1'b0;
            end
            else
            begin
                hd_next = 1'b1;
                if (hdr)
                begin
                    cur_w_next = w_sel;
                    cur_h_next = h_sel;
                end
                if (col_inc >= w_sel)
                begin
                    col_next = 14'd0;
                    if (row_inc >= h_sel)
                    begin
                        row_next = 14'd0;
                        if (hdr)
                        begin
                            tp_next = 1'b1;
                        end
                        else
                        begin
                            hd_next = 1'b0;
                        end
                    end
                    else
                    begin
                        row_next = row_inc[13:0];
                    end
                end
                else
                begin
                    col_next = col_inc[13:0];
                    row_next = row_base;
                end
            end
        end
    end

    // framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 15'd1;
            height_reg <= 15'd1;
            cur_w_reg  <= 15'd1;
            cur_h_reg  <= 15'd1;
            col_reg    <= '0;
            row_reg    <= '0;
            hd_reg     <= 1'b0;
            tp_reg     <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            cur_w_reg  <= cur_w_next;
            cur_h_reg  <= cur_h_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            hd_reg     <= hd_next;
            tp_reg     <= tp_next;
        end
    end

endmodule

// File: rtl/psd_queue.sv
// ----------------------------------------------------------------------------
// psd_queue
// Four-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module psd_queue
    import psd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    output logic head_valid,
    output cmd_t head_data,
    input  logic pop
);

    localparam int DEPTH = 4;

    cmd_t        mem_reg [DEPTH];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == 3'(DEPTH));
    assign head_valid = (cnt_reg != 3'd0);
    assign head_data  = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        cnt_next    = cnt_reg + {2'd0, push} - {2'd0, pop};
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: rtl/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// Division by a fixed divisor through a reciprocal multiply.
// ----------------------------------------------------------------------------
module psd_div
    import psd_pkg::*;
#(
    parameter int unsigned DIVISOR = 65535
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    // reciprocal scaled so the high product bits give the exact quotient
    // for every dividend below 2**31
    localparam int unsigned SHIFT      = 31 + $clog2(DIVISOR);
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];

    logic [31:0] x_reg, x_next;
    logic [31:0] q_reg, q_next;
    logic        busy_reg, busy_next;
    logic [63:0] prod;

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = q_reg;

    // capture the dividend, then take the quotient from the product
    always_comb
    begin
        prod      = 64'(x_reg) * 64'(RECIP);
        x_next    = x_reg;
        q_next    = q_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            x_next    = req.dividend;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next    = 32'(prod >> SHIFT);
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            q_reg    <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            x_reg    <= x_next;
            q_reg    <= q_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// File: rtl/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Byte sequencer: header, stored block framing, raw data, checksums, trailer.
// ----------------------------------------------------------------------------
`include "png_stored_deflate_encoder_defines.svh"

module psd_back
    import psd_pkg::*;
#(
    parameter int unsigned STORED_BLOCK_LIMIT = 65535
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_data,
    output logic       q_pop,
    output div_req_t   div_req,
    input  div_rsp_t   div_rsp,
    psd_byte_if.source res
);

    localparam logic [15:0] BLK_LIM = 16'(STORED_BLOCK_LIMIT);

    typedef enum logic [2:0] {PH_IDLE, PH_HEAD, PH_BLK, PH_DATA, PH_TAIL} phase_t;

    phase_t      phase_reg, phase_next;
    cmd_t        cmd_reg, cmd_next;
    logic [5:0]  idx_reg, idx_next;
    logic [2:0]  ridx_reg, ridx_next;
    logic [6:0]  ocount_reg, ocount_next;
    logic [30:0] raw_reg, raw_next;
    logic [15:0] block_left_reg, block_left_next;
    logic [15:0] adler_lo_reg, adler_lo_next;
    logic [15:0] adler_hi_reg, adler_hi_next;
    logic [31:0] crc_reg, crc_next;
    logic        ov_reg, ov_next;
    logic [7:0]  byte_reg, byte_next;
    logic        run_end_reg, run_end_next;
    logic        fend_reg, fend_next;

    logic        adv, step, stall, emit, crc_en, last, fend;
    logic [7:0]  bsel, dbyte;
    logic [31:0] prod, zlen, crc_x, adler_word;
    logic [16:0] w4;
    logic [15:0] blen, nlen, blk_dec;
    logic [16:0] lo_sum, hi_sum;
    logic [15:0] lo_new, hi_new;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
        end
        return x;
    endfunction

    assign res.valid    = ov_reg;
    assign res.out_byte = byte_reg;
    assign res.run_end  = run_end_reg;
    assign res.file_end = fend_reg;

    // arithmetic feeding the byte mux
    always_comb
    begin
        w4         = {cmd_reg.w, 2'b00} + 17'd1;
        prod       = 32'(cmd_reg.h) * 32'(w4);
        zlen       = div_rsp.quotient + (div_rsp.quotient << 2) + 32'(raw_reg) + 32'd6;
        crc_x      = crc_reg ^ CRC_INIT;
        adler_word = {adler_hi_reg, adler_lo_reg};
        blen       = (raw_reg < 31'(BLK_LIM)) ? raw_reg[15:0] : BLK_LIM;
        nlen       = ~blen;
        blk_dec    = (block_left_reg != 16'd0) ? block_left_reg - 16'd1 : block_left_reg;
        unique case (ridx_reg)
            3'd1:    dbyte = cmd_reg.pixel[31:24];
            3'd2:    dbyte = cmd_reg.pixel[23:16];
            3'd3:    dbyte = cmd_reg.pixel[15:8];
            3'd4:    dbyte = cmd_reg.pixel[7:0];
            default: dbyte = 8'd0;
        endcase
        lo_sum = {1'b0, adler_lo_reg} + {9'd0, dbyte};
        lo_new = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
        hi_sum = {1'b0, adler_hi_reg} + {1'b0, lo_new};
        hi_new = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
    end

    // byte selection per phase
    always_comb
    begin
        bsel   = 8'd0;
        crc_en = 1'b0;
        last   = 1'b0;
        fend   = 1'b0;
        stall  = 1'b0;
        unique case (phase_reg)
            PH_HEAD:
            begin
                crc_en = (idx_reg >= 6'd12 && idx_reg <= 6'd28) || idx_reg >= 6'd37;
                stall  = idx_reg >= 6'd33 && idx_reg <= 6'd36 && div_rsp.busy;
                unique case (idx_reg)
                    6'd0:  bsel = 8'h89;
                    6'd1:  bsel = 8'h50;
                    6'd2:  bsel = 8'h4E;
                    6'd3:  bsel = 8'h47;
                    6'd4:  bsel = 8'h0D;
                    6'd5:  bsel = 8'h0A;
                    6'd6:  bsel = 8'h1A;
                    6'd7:  bsel = 8'h0A;
                    6'd11: bsel = 8'h0D;
                    6'd12: bsel = 8'h49;
                    6'd13: bsel = 8'h48;
                    6'd14: bsel = 8'h44;
                    6'd15: bsel = 8'h52;
                    6'd18: bsel = {1'b0, cmd_reg.w[14:8]};
                    6'd19: bsel = cmd_reg.w[7:0];
                    6'd22: bsel = {1'b0, cmd_reg.h[14:8]};
                    6'd23: bsel = cmd_reg.h[7:0];
                    6'd24: bsel = 8'h08;
                    6'd25: bsel = 8'h06;
                    6'd29: bsel = crc_x[31:24];
                    6'd30: bsel = crc_x[23:16];
                    6'd31: bsel = crc_x[15:8];
                    6'd32: bsel = crc_x[7:0];
                    6'd33: bsel = zlen[31:24];
                    6'd34: bsel = zlen[23:16];
                    6'd35: bsel = zlen[15:8];
                    6'd36: bsel = zlen[7:0];
                    6'd37: bsel = 8'h49;
                    6'd38: bsel = 8'h44;
                    6'd39: bsel = 8'h41;
                    6'd40: bsel = 8'h54;
                    6'd41: bsel = 8'h78;
                    6'd42: bsel = 8'h01;
                    default: bsel = 8'h00;
                endcase
            end
            PH_BLK:
            begin
                crc_en = 1'b1;
                unique case (idx_reg)
                    6'd0:    bsel = {7'd0, ({15'd0, blen} == raw_reg)};
                    6'd1:    bsel = blen[7:0];
                    6'd2:    bsel = blen[15:8];
                    6'd3:    bsel = nlen[7:0];
                    default: bsel = nlen[15:8];
                endcase
            end
            PH_DATA:
            begin
                crc_en = 1'b1;
                bsel   = dbyte;
                last   = (ridx_reg == 3'd4) && !cmd_reg.tail_after;
            end
            PH_TAIL:
            begin
                crc_en = idx_reg <= 6'd3 || (idx_reg >= 6'd12 && idx_reg <= 6'd15);
                last   = (idx_reg == TAIL_LAST);
                fend   = (idx_reg == TAIL_LAST);
                unique case (idx_reg)
                    6'd0:  bsel = adler_word[31:24];
                    6'd1:  bsel = adler_word[23:16];
                    6'd2:  bsel = adler_word[15:8];
                    6'd3:  bsel = adler_word[7:0];
                    6'd4:  bsel = crc_x[31:24];
                    6'd5:  bsel = crc_x[23:16];
                    6'd6:  bsel = crc_x[15:8];
                    6'd7:  bsel = crc_x[7:0];
                    6'd12: bsel = 8'h49;
                    6'd13: bsel = 8'h45;
                    6'd14: bsel = 8'h4E;
                    6'd15: bsel = 8'h44;
                    6'd16: bsel = crc_x[31:24];
                    6'd17: bsel = crc_x[23:16];
                    6'd18: bsel = crc_x[15:8];
                    6'd19: bsel = crc_x[7:0];
                    default: bsel = 8'h00;
                endcase
            end
            default:
            begin
                bsel = 8'h00;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        ridx_next       = ridx_reg;
        ocount_next     = ocount_reg;
        raw_next        = raw_reg;
        block_left_next = block_left_reg;
        adler_lo_next   = adler_lo_reg;
        adler_hi_next   = adler_hi_reg;
        crc_next        = crc_reg;
        ov_next         = ov_reg;
        byte_next       = byte_reg;
        run_end_next    = run_end_reg;
        fend_next       = fend_reg;
        q_pop           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = 32'(raw_reg) + 32'(BLK_LIM) - 32'd1;

        adv  = !ov_reg || res.ready;
        step = adv && !stall && phase_reg != PH_IDLE;
        emit = ocount_reg < 7'(MAX_OUT);

        if (ov_reg && res.ready)
        begin
            ov_next = 1'b0;
        end

        // output register and crc
        if (step && emit)
        begin
            ov_next      = 1'b1;
            byte_next    = bsel;
            run_end_next = last || (ocount_reg == 7'(MAX_OUT - 1));
            fend_next    = fend;
            ocount_next  = ocount_reg + 7'd1;
            if (crc_en)
            begin
                crc_next = crc_step(crc_reg, bsel);
            end
        end

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    cmd_next    = q_data;
                    ocount_next = '0;
                    idx_next    = '0;
                    ridx_next   = q_data.filter ? 3'd0 : 3'd1;
                    if (q_data.tail_only)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else if (q_data.hdr)
                    begin
                        phase_next = PH_HEAD;
                    end
                    else
                    begin
                        phase_next = (block_left_reg == 16'd0) ? PH_BLK : PH_DATA;
                    end
                end
            end
            PH_HEAD:
            begin
                if (step)
                begin
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg == 6'd0)
                    begin
                        raw_next        = prod[30:0];
                        adler_lo_next   = 16'd1;
                        adler_hi_next   = 16'd0;
                        block_left_next = 16'd0;
                    end
                    if (idx_reg == 6'd1)
                    begin
                        div_req.start = 1'b1;
                    end
                    if (idx_reg == 6'd11 || idx_reg == 6'd36)
                    begin
                        crc_next = CRC_INIT;
                    end
                    if (idx_reg == HEAD_LAST)
                    begin
                        idx_next   = '0;
                        phase_next = PH_BLK;
                    end
                end
            end
            PH_BLK:
            begin
                if (step)
                begin
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg == BLK_LAST)
                    begin
                        idx_next        = '0;
                        block_left_next = blen;
                        phase_next      = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (step)
                begin
                    adler_lo_next   = lo_new;
                    adler_hi_next   = hi_new;
                    block_left_next = blk_dec;
                    raw_next        = (raw_reg != 31'd0) ? raw_reg - 31'd1 : raw_reg;
                    if (ridx_reg == 3'd4)
                    begin
                        phase_next = cmd_reg.tail_after ? PH_TAIL : PH_IDLE;
                    end
                    else
                    begin
                        ridx_next  = ridx_reg + 3'd1;
                        phase_next = (blk_dec == 16'd0) ? PH_BLK : PH_DATA;
                    end
                end
            end
            PH_TAIL:
            begin
                if (step)
                begin
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg == 6'd11)
                    begin
                        crc_next = CRC_INIT;
                    end
                    if (idx_reg == TAIL_LAST)
                    begin
                        idx_next   = '0;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            cmd_reg        <= '0;
            idx_reg        <= '0;
            ridx_reg       <= '0;
            ocount_reg     <= '0;
            raw_reg        <= '0;
            block_left_reg <= '0;
            adler_lo_reg   <= 16'd1;
            adler_hi_reg   <= 16'd0;
            crc_reg        <= CRC_INIT;
            ov_reg         <= 1'b0;
            byte_reg       <= '0;
            run_end_reg    <= 1'b0;
            fend_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            cmd_reg        <= cmd_next;
            idx_reg        <= idx_next;
            ridx_reg       <= ridx_next;
            ocount_reg     <= ocount_next;
            raw_reg        <= raw_next;
            block_left_reg <= block_left_next;
            adler_lo_reg   <= adler_lo_next;
            adler_hi_reg   <= adler_hi_next;
            crc_reg        <= crc_next;
            ov_reg         <= ov_next;
            byte_reg       <= byte_next;
            run_end_reg    <= run_end_next;
            fend_reg       <= fend_next;
        end
    end

    // checks
    `PSD_ASSERT_NOW(a_fend_run, ov_reg && fend_reg, run_end_reg, "file end byte not closing its item")
    `PSD_ASSERT_NOW(a_blk_lim, 1'b1, block_left_reg <= BLK_LIM, "stored block count above limit")
    `PSD_ASSERT_NOW(a_ocount, 1'b1, ocount_reg <= 7'(MAX_OUT), "byte count of an item above limit")
    `PSD_ASSERT_NEXT(a_div_start, div_req.start, div_rsp.busy, "length divider did not start")

endmodule

// File: rtl/png_stored_deflate_encoder.sv
// Usage:
// pix carries one RGBA8 pixel per item in raster order; res carries the PNG
// file one byte per item, with run_end on the last byte a pixel causes and
// file_end on the final byte of the file. cfg writes image_width (index 0)
// and image_height (index 1); they are sampled at the first pixel of an image.
// A front stage classifies pixels into a four-entry queue; a back sequencer
// drains it at one output byte per cycle while res is ready. A plain pixel
// takes a dispatch step and then 4 data bytes, plus a row filter byte at a
// row start and 5 bytes per stored block header. The first pixel of an
// image adds the 43-byte header; its length field uses a reciprocal block
// count started at the second header byte, ready long before it is needed.
// The last pixel adds 20 trailer bytes; for a one-pixel image they follow
// the next pixel, which is dropped. When idle, an accepted pixel passes the
// queue and the back item register before its first byte is registered.
// Reset clears framing, checksums and the queue; the next pixel starts a file.
// When res stalls, the output register holds and the queue keeps taking
// pixels until it is full, then pix.ready drops.
// ----------------------------------------------------------------------------
// png_stored_deflate_encoder
// Streaming RGBA8 PNG encoder using stored deflate blocks.
// ----------------------------------------------------------------------------
module png_stored_deflate_encoder
    import psd_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION      = 16384,
    parameter int unsigned STORED_BLOCK_LIMIT = 65535
)
(
    input  logic       clk,
    input  logic       rst_n,
    psd_cfg_if.sink    cfg,
    psd_pix_if.sink    pix,
    psd_byte_if.source res
);

    logic     q_push, q_full, q_valid, q_pop;
    cmd_t     q_in, q_out;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // front: accept and classify
    psd_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .pix    (pix),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    // decoupling queue
    psd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  (q_out),
        .pop        (q_pop)
    );

    // block count divider
    psd_div #(.DIVISOR(STORED_BLOCK_LIMIT)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // back: byte sequencer
    psd_back #(.STORED_BLOCK_LIMIT(STORED_BLOCK_LIMIT)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .res     (res)
    );

endmodule
